// ----- hw/rtl/ata_pio_lba28_request_sequencer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ATA PIO LBA28 request sequencer
// Immediate-free concurrent property wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_LBA28_REQUEST_SEQUENCER_ASSERT_SVH
`define ATA_PIO_LBA28_REQUEST_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define APS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define APS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define APS_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define APS_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- hw/rtl/aps_pkg.sv -----
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and constants of the ATA PIO LBA28 request sequencer.
// ----------------------------------------------------------------------------
package aps_pkg;
	localparam int QueueDepthDef = 8;
	localparam int ChunkLimitDef = 256;
	localparam int CountBitsDef  = 16;
	localparam int TagBitsDef    = 8;

	localparam logic [27:0] Lba28Mask = 28'hfff_ffff;
	localparam logic [7:0]  CmdRead   = 8'h20;
	localparam logic [7:0]  CmdWrite  = 8'h30;

	// result actions
	localparam logic [3:0] ActRegWr   = 4'd0;
	localparam logic [3:0] ActRdSec   = 4'd1;
	localparam logic [3:0] ActWrSec   = 4'd2;
	localparam logic [3:0] ActSecDone = 4'd3;
	localparam logic [3:0] ActIoErr   = 4'd4;
	localparam logic [3:0] ActRange   = 4'd5;
	localparam logic [3:0] ActFull    = 4'd6;
	localparam logic [3:0] ActNotHnd  = 4'd7;
	localparam logic [3:0] ActQueued  = 4'd8;

	// task-file registers
	localparam logic [2:0] RegSecCnt = 3'd2;
	localparam logic [2:0] RegSecNum = 3'd3;
	localparam logic [2:0] RegCylLo  = 3'd4;
	localparam logic [2:0] RegCylHi  = 3'd5;
	localparam logic [2:0] RegHead   = 3'd6;
	localparam logic [2:0] RegCmd    = 3'd7;

	// configuration register indexes
	localparam logic RegIdxSlave = 1'b0;
	localparam logic RegIdxBlocks = 1'b1;

	// one result word
	typedef struct packed {
		logic        last;
		logic        handled;
		logic [31:0] lba;
		logic [7:0]  tag;
		logic [7:0]  value;
		logic [2:0]  index;
		logic [3:0]  action;
	} result_t;
endpackage

// ----- hw/rtl/ata_pio_lba28_request_sequencer.sv -----
// ----------------------------------------------------------------------------
// ata_pio_lba28_request_sequencer
// Host-side ATA PIO LBA28 request sequencer: queue, range check, task file.
// ----------------------------------------------------------------------------
// channel | direction | contents
// s_axis  | in        | tuser kind; tdata tag, is_write, lba, sector_count, status
// m_axis  | out       | tuser action; tdata reg_index..report_lba, handled; tlast
// cfg     | in        | wr_en, wr_index, wr_data (is_slave, block_count)
// One input item passes through the front stage, then through the sequencer states;
// the sector bookkeeping state and the write-claim decision emit nothing.
// Reset clears the queue pointers, fill count and sequencer state.
// A stall on the output holds the sequencer; the front keeps one item ready.
module ata_pio_lba28_request_sequencer #(
	parameter int QueueDepth = aps_pkg::QueueDepthDef,
	parameter int ChunkLimit = aps_pkg::ChunkLimitDef,
	parameter int CountBits  = aps_pkg::CountBitsDef,
	parameter int TagBits    = aps_pkg::TagBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [31:0] wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: tag, is_write, lba, sector_count, status (from bit 0)
	input  logic [((TagBits + CountBits + 41 + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// tuser: kind
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: reg_index, reg_value, report_tag, report_lba, handled (from bit 0)
	output logic [55:0] m_axis_tdata,
	// tuser: action
	output logic [3:0]  m_axis_tuser,
	output logic        m_axis_tlast
);
	import aps_pkg::*;
	`include "ata_pio_lba28_request_sequencer_assert.svh"

	localparam int LbaLo = TagBits + 1;
	localparam int CntLo = LbaLo + 32;
	localparam int StLo  = CntLo + CountBits;

	logic        is_slave_q;
	logic [31:0] block_count_q;
	logic        cmd_valid, cmd_ready, cmd_kind, cmd_range, cmd_wr;
	logic [TagBits-1:0] cmd_tag;
	logic [31:0] cmd_lba;
	logic [CountBits-1:0] cmd_cnt;
	logic [7:0]  cmd_status;
	logic        res_room, res_push, res_empty, busy;
	result_t     res_data, out_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_slave_q <= 1'b0;
			block_count_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				RegIdxSlave: is_slave_q <= wr_data[0];
				RegIdxBlocks: block_count_q <= wr_data;
				default: ;
			endcase
		end
	end

	aps_front #(.CountBits(CountBits), .TagBits(TagBits)) u_front (
		.clk, .arst_n, .block_count(block_count_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.kind(s_axis_tuser), .tag(s_axis_tdata[TagBits-1:0]),
		.is_write(s_axis_tdata[TagBits]), .lba(s_axis_tdata[LbaLo +: 32]),
		.sector_count(s_axis_tdata[CntLo +: CountBits]),
		.status(s_axis_tdata[StLo +: 8]),
		.cmd_valid, .cmd_ready, .cmd_kind, .cmd_range, .cmd_tag, .cmd_wr,
		.cmd_lba, .cmd_cnt, .cmd_status
	);

	aps_back #(.QueueDepth(QueueDepth), .ChunkLimit(ChunkLimit),
		.CountBits(CountBits), .TagBits(TagBits)) u_back (
		.clk, .arst_n, .is_slave(is_slave_q),
		.cmd_valid, .cmd_ready, .cmd_kind, .cmd_range, .cmd_tag, .cmd_wr,
		.cmd_lba, .cmd_cnt, .cmd_status,
		.res_room, .res_push, .res_data, .busy
	);

	aps_out_fifo u_out (
		.clk, .arst_n, .push(res_push), .push_data(res_data), .has_room(res_room),
		.empty(res_empty), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data
	);

	assign m_axis_tuser = out_data.action;
	assign m_axis_tlast = out_data.last;
	assign m_axis_tdata = {4'b0, out_data.handled, out_data.lba, out_data.tag,
		out_data.value, out_data.index};

	// handled only rides on the final result
	`APS_ASSERT_NEVER(a_handled_last, clk, arst_n,
		m_axis_tvalid && m_axis_tdata[51] && !m_axis_tlast, "handled without last")
	// register writes carry no tag
	`APS_ASSERT_NEVER(a_regwr_tag, clk, arst_n,
		res_push && res_data.action == ActRegWr && res_data.tag != 8'd0, "tag on reg write")
	// nothing is produced while the sequencer idles without a command
	`APS_ASSERT_IMPL(a_idle_quiet, clk, arst_n,
		(!busy && !cmd_valid) |-> !res_push, "result while idle")
	// output fifo never reports empty while showing data
	`APS_ASSERT_NEVER(a_fifo_flags, clk, arst_n, res_empty && m_axis_tvalid, "fifo flags")
endmodule

// ----- hw/rtl/aps_out_fifo.sv -----
// ----------------------------------------------------------------------------
// aps_out_fifo
// Short result queue between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module aps_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  aps_pkg::result_t push_data,
	output logic             has_room,
	output logic             empty,
	output logic             out_valid,
	input  logic             out_ready,
	output aps_pkg::result_t out_data
);
	import aps_pkg::*;

	result_t    mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != 3'd0;
	assign empty     = cnt_q == 3'd0;
	assign has_room  = cnt_q < 3'd3;
	assign out_data  = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end
endmodule

// ----- hw/rtl/aps_front.sv -----
// ----------------------------------------------------------------------------
// aps_front
// Takes input items, checks submits against the block count and for a zero sector
// count, and hands classified commands to the sequencer through a one-entry stage.
// ----------------------------------------------------------------------------
module aps_front #(
	parameter int CountBits = aps_pkg::CountBitsDef,
	parameter int TagBits   = aps_pkg::TagBitsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [31:0]          block_count,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [TagBits-1:0]   tag,
	input  logic                 is_write,
	input  logic [31:0]          lba,
	input  logic [CountBits-1:0] sector_count,
	input  logic [7:0]           status,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output logic                 cmd_kind,
	output logic                 cmd_range,
	output logic [TagBits-1:0]   cmd_tag,
	output logic                 cmd_wr,
	output logic [31:0]          cmd_lba,
	output logic [CountBits-1:0] cmd_cnt,
	output logic [7:0]           cmd_status
);
	// single-entry holding stage with range flag
	logic                 full_q;
	logic                 kind_q, range_q, wr_q;
	logic [TagBits-1:0]   tag_q;
	logic [31:0]          lba_q;
	logic [CountBits-1:0] cnt_q;
	logic [7:0]           st_q;
	logic [32:0]          sum;

	assign sum      = {1'b0, lba} + 33'(sector_count);
	assign in_ready = !full_q || cmd_ready;
	assign cmd_valid = full_q;
	assign cmd_kind = kind_q;
	assign cmd_range = range_q;
	assign cmd_tag = tag_q;
	assign cmd_wr = wr_q;
	assign cmd_lba = lba_q;
	assign cmd_cnt = cnt_q;
	assign cmd_status = st_q;

	// payload capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q  <= kind;
			range_q <= (sector_count == '0) || (sum > {1'b0, block_count});
			wr_q    <= is_write;
			tag_q   <= tag;
			lba_q   <= lba;
			cnt_q   <= sector_count;
			st_q    <= status;
		end
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) full_q <= 1'b0;
		else if (in_valid && in_ready) full_q <= 1'b1;
		else if (cmd_ready) full_q <= 1'b0;
	end
endmodule

// ----- hw/rtl/aps_back.sv -----
// ----------------------------------------------------------------------------
// aps_back
// Holds the request queue and chunk counter; steps through the task-file writes and
// reports of one command, stalling while the output lacks room, before it takes another.
// ----------------------------------------------------------------------------
module aps_back #(
	parameter int QueueDepth = aps_pkg::QueueDepthDef,
	parameter int ChunkLimit = aps_pkg::ChunkLimitDef,
	parameter int CountBits  = aps_pkg::CountBitsDef,
	parameter int TagBits    = aps_pkg::TagBitsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 is_slave,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  logic                 cmd_kind,
	input  logic                 cmd_range,
	input  logic [TagBits-1:0]   cmd_tag,
	input  logic                 cmd_wr,
	input  logic [31:0]          cmd_lba,
	input  logic [CountBits-1:0] cmd_cnt,
	input  logic [7:0]           cmd_status,
	input  logic                 res_room,
	output logic                 res_push,
	output aps_pkg::result_t     res_data,
	output logic                 busy
);
	import aps_pkg::*;

	localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int FillBits = $clog2(QueueDepth + 1);
	localparam int ChunkBits = $clog2(ChunkLimit + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_DECIDE, S_HEAD, S_CYLHI, S_CYLLO, S_SECNUM, S_SECCNT, S_CMD,
		S_WRSEC, S_XFER, S_DONE, S_DRAIN
	} state_t;

	state_t               state_q;
	logic [TagBits-1:0]   qtag_q [QueueDepth];
	logic                 qwr_q [QueueDepth];
	logic [31:0]          qlba_q [QueueDepth];
	logic [CountBits-1:0] qcnt_q [QueueDepth];
	logic [PtrBits-1:0]   rp_q, wp_q;
	logic [FillBits-1:0]  fill_q;
	logic [ChunkBits-1:0] chunk_q;
	logic [7:0]           st_q;
	logic                 err_q;

	// head entry
	logic [TagBits-1:0]   h_tag;
	logic                 h_wr;
	logic [31:0]          h_lba;
	logic [CountBits-1:0] h_cnt;
	logic [27:0]          l28;
	logic [ChunkBits-1:0] chunk_n;
	logic                 claim;
	logic [7:0]           head_sel;

	assign h_tag = qtag_q[rp_q];
	assign h_wr  = qwr_q[rp_q];
	assign h_lba = qlba_q[rp_q];
	assign h_cnt = qcnt_q[rp_q];
	assign l28   = h_lba[27:0] & Lba28Mask;
	assign chunk_n = (32'(h_cnt) < ChunkLimit) ? ChunkBits'(h_cnt) : ChunkBits'(ChunkLimit);
	assign claim = h_wr ? !st_q[7] : (st_q[0] || st_q[3]);
	assign head_sel = 8'hE0 | {3'b0, is_slave, 4'b0};

	assign cmd_ready = (state_q == S_IDLE) && res_room;
	assign busy = state_q != S_IDLE;

	function automatic logic [PtrBits-1:0] ptr_inc(input logic [PtrBits-1:0] p);
		ptr_inc = (32'(p) == QueueDepth - 1) ? '0 : p + PtrBits'(1);
	endfunction

	// result word for the current state
	always_comb begin
		res_push = 1'b0;
		res_data = '0;
		if (res_room) begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						res_push = 1'b1;
						if (!cmd_kind) begin
							res_data.tag = 8'(cmd_tag);
							res_data.lba = cmd_lba;
							if (cmd_range) res_data.action = ActRange;
							else if (32'(fill_q) >= QueueDepth) res_data.action = ActFull;
							else res_data.action = ActQueued;
							res_data.last = cmd_range || (32'(fill_q) >= QueueDepth)
								|| (fill_q != '0);
						end else if (fill_q == '0) begin
							res_data.action = ActNotHnd;
							res_data.last = 1'b1;
						end else begin
							res_data.action = ActRegWr;
							res_data.index = RegHead;
							res_data.value = head_sel;
						end
					end
				end
				S_DECIDE: begin
					res_push = 1'b1;
					if (!claim) begin
						res_data.action = ActNotHnd;
						res_data.last = 1'b1;
					end else if (st_q[0]) begin
						res_data.action = ActIoErr;
						res_data.tag = 8'(h_tag);
						res_data.lba = h_lba;
					end else if (!h_wr) begin
						res_data.action = ActRdSec;
						res_data.tag = 8'(h_tag);
						res_data.lba = h_lba;
					end else begin
						res_push = 1'b0;
					end
				end
				S_HEAD: begin
					res_push = 1'b1;
					res_data.index = RegHead;
					res_data.value = head_sel | {4'b0, l28[27:24]};
				end
				S_CYLHI: begin
					res_push = 1'b1; res_data.index = RegCylHi; res_data.value = l28[23:16];
				end
				S_CYLLO: begin
					res_push = 1'b1; res_data.index = RegCylLo; res_data.value = l28[15:8];
				end
				S_SECNUM: begin
					res_push = 1'b1; res_data.index = RegSecNum; res_data.value = l28[7:0];
				end
				S_SECCNT: begin
					res_push = 1'b1; res_data.index = RegSecCnt; res_data.value = 8'(chunk_n);
				end
				S_CMD: begin
					res_push = 1'b1;
					res_data.index = RegCmd;
					res_data.value = h_wr ? CmdWrite : CmdRead;
					res_data.last = !h_wr;
					res_data.handled = !h_wr && err_q;
				end
				S_WRSEC: begin
					res_push = 1'b1;
					res_data.action = ActWrSec;
					res_data.tag = 8'(h_tag);
					res_data.lba = h_lba;
					res_data.last = 1'b1;
					res_data.handled = err_q;
				end
				S_DONE: begin
					// sector done is last only when the read request continues in this chunk
					res_push = 1'b1;
					res_data.action = ActSecDone;
					res_data.tag = 8'(h_tag);
					res_data.lba = h_lba;
					res_data.last = (h_cnt != '0) && (chunk_q != '0) && !h_wr;
					res_data.handled = (h_cnt != '0) && (chunk_q != '0) && !h_wr;
				end
				S_DRAIN: begin
					res_push = 1'b1;
					res_data.index = RegHead;
					res_data.value = is_slave ? 8'h00 : 8'h10;
					res_data.last = 1'b1;
					res_data.handled = 1'b1;
				end
				default: res_push = 1'b0;
			endcase
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready && !cmd_kind && !cmd_range
			&& 32'(fill_q) < QueueDepth) begin
			qtag_q[wp_q] <= cmd_tag;
			qwr_q[wp_q]  <= cmd_wr;
			qlba_q[wp_q] <= cmd_lba;
			qcnt_q[wp_q] <= cmd_cnt;
		end else if (state_q == S_XFER && res_room) begin
			qlba_q[rp_q] <= h_lba + 32'd1;
			if (h_cnt != '0) qcnt_q[rp_q] <= h_cnt - CountBits'(1);
		end
	end

	// sequencer; err_q marks a claimed interrupt so the final result carries handled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rp_q <= '0; wp_q <= '0; fill_q <= '0; chunk_q <= '0;
			st_q <= '0; err_q <= 1'b0;
		end else if (res_room) begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						st_q <= cmd_status;
						err_q <= 1'b0;
						if (!cmd_kind) begin
							if (!cmd_range && 32'(fill_q) < QueueDepth) begin
								wp_q <= ptr_inc(wp_q);
								fill_q <= fill_q + FillBits'(1);
								if (fill_q == '0) state_q <= S_HEAD;
							end
						end else if (fill_q != '0) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					if (!claim) state_q <= S_IDLE;
					else begin
						err_q <= 1'b1;
						if (st_q[0]) begin
							rp_q <= ptr_inc(rp_q);
							fill_q <= fill_q - FillBits'(1);
							state_q <= (fill_q > FillBits'(1)) ? S_HEAD : S_DRAIN;
						end else state_q <= S_XFER;
					end
				end
				S_HEAD: state_q <= S_CYLHI;
				S_CYLHI: state_q <= S_CYLLO;
				S_CYLLO: state_q <= S_SECNUM;
				S_SECNUM: state_q <= S_SECCNT;
				S_SECCNT: begin
					chunk_q <= chunk_n;
					state_q <= S_CMD;
				end
				S_CMD: state_q <= h_wr ? S_WRSEC : S_IDLE;
				S_WRSEC: state_q <= S_IDLE;
				S_XFER: begin
					if (chunk_q != '0) chunk_q <= chunk_q - ChunkBits'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (h_cnt == '0) begin
						rp_q <= ptr_inc(rp_q);
						fill_q <= fill_q - FillBits'(1);
						state_q <= (fill_q > FillBits'(1)) ? S_HEAD : S_DRAIN;
					end else if (chunk_q == '0) state_q <= S_HEAD;
					else if (h_wr) state_q <= S_WRSEC;
					else state_q <= S_IDLE;
				end
				S_DRAIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
